[sv/rsti_pkg.sv]
package rsti_pkg;

	// Default sizing
	localparam int MAX_DIGITS_DEF = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Port types
	localparam int CFG_INDEX_W = 2;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [63:0]            cfg_data_t;
	typedef logic [7:0]             char_t;
	typedef logic [1:0]             status_t;
	typedef logic signed [31:0]     number_t;

	// Register indexes
	localparam cfg_index_t REG_ALPHABET_LOW  = cfg_index_t'(0);
	localparam cfg_index_t REG_ALPHABET_HIGH = cfg_index_t'(1);

	// Result status codes
	localparam status_t STATUS_OK           = 2'd0;
	localparam status_t STATUS_BAD_DIGIT    = 2'd1;
	localparam status_t STATUS_BAD_ALPHABET = 2'd2;

	// Characters of interest
	localparam char_t CHAR_NUL      = 8'h00;
	localparam char_t CHAR_TAB      = 8'h09;
	localparam char_t CHAR_CR       = 8'h0D;
	localparam char_t CHAR_SPACE    = 8'h20;
	localparam char_t CHAR_MIN_SHOW = 8'h21;
	localparam char_t CHAR_PERCENT  = 8'h25;
	localparam char_t CHAR_STAR     = 8'h2A;
	localparam char_t CHAR_PLUS     = 8'h2B;
	localparam char_t CHAR_MINUS    = 8'h2D;
	localparam char_t CHAR_SLASH    = 8'h2F;
	localparam char_t CHAR_DEL      = 8'h7F;

	function automatic logic is_space(input char_t c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	// Characters that may not stand in a digit alphabet
	function automatic logic is_forbidden_digit(input char_t c);
		return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
			(c == CHAR_SLASH) || (c == CHAR_PERCENT) || (c == CHAR_DEL) ||
			(c < CHAR_MIN_SHOW);
	endfunction

endpackage

[sv/radix_string_to_integer.sv]
// Radix string to integer over a programmable digit alphabet.
//
// Channels: text bytes enter on in_valid/in_ready (text_byte), one beat per
// character; a zero byte ends the string. Each finished string leaves as one
// beat on out_valid/out_ready carrying status and number. The alphabet is
// written on cfg_valid/cfg_ready (cfg_index, cfg_data); cfg_ready is always
// high and writes land at once. Write the alphabet only while no string is
// in flight.
//
// Throughput: one text byte per cycle, except while a terminator is held (see
// Stall below); the digit lookup is a parallel compare over the alphabet and
// the accumulate a single multiply-add by the base (at most MAX_DIGITS, so a
// narrow multiplier). A terminator passes the input register, then the output
// register; it waits in the input register while a result is not yet taken.
//
// Stall: while a result waits in the output register, ordinary bytes keep
// flowing; only a second terminator is held in the input register, and
// in_ready drops, until the receiver takes the waiting beat.
// Reset: clears the alphabet (so it is invalid), the string state and both
// valid flags. A terminator returns the string state to its reset value.
module radix_string_to_integer #(
	parameter int MAX_DIGITS = rsti_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rsti_pkg::cfg_index_t cfg_index,
	input  rsti_pkg::cfg_data_t  cfg_data,
	// text input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rsti_pkg::char_t      text_byte,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsti_pkg::status_t    status,
	output rsti_pkg::number_t    number
);
	import rsti_pkg::*;

	localparam int LEN_W = $clog2(MAX_DIGITS + 1);
	localparam int DIG_W = $clog2(MAX_DIGITS);

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGIT,
		PH_BAD
	} phase_t;

	// Alphabet registers
	logic [63:0] alpha_low_q;
	logic [63:0] alpha_high_q;

	// Input register
	logic  valid_s1;
	char_t byte_s1;

	// String state
	phase_t                phase_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] acc_q;

	// Output register
	logic    out_valid_q;
	status_t status_q;
	number_t number_q;

	// Alphabet decode
	logic [127:0]     alpha_all;
	char_t            alpha_char [MAX_DIGITS];
	logic [LEN_W-1:0] alpha_len;
	logic             alpha_ok;
	logic             hit;
	logic [DIG_W-1:0] digit;

	// Datapath
	logic                  is_term;
	logic                  out_free;
	logic                  advance;
	logic                  take_result;
	phase_t                phase_d;
	logic                  neg_d;
	logic [VALUE_BITS-1:0] acc_d;
	logic [VALUE_BITS-1:0] value;
	logic [63:0]           value_wide;
	status_t               status_d;
	number_t               number_d;

	// Alphabet bytes, digit k at byte k of the 128-bit pair
	assign alpha_all = {alpha_high_q, alpha_low_q};

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			alpha_char[k] = alpha_all[k*8 +: 8];
		end
	end

	// Length: position of the first zero byte, capped at MAX_DIGITS
	always_comb begin
		alpha_len = LEN_W'(MAX_DIGITS);
		for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
			if (alpha_char[k] == CHAR_NUL) begin
				alpha_len = LEN_W'(k);
			end
		end
	end

	// Validity: length, forbidden characters, duplicates
	always_comb begin
		alpha_ok = (alpha_len >= LEN_W'(2));
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (LEN_W'(i) < alpha_len) begin
				if (is_forbidden_digit(alpha_char[i])) begin
					alpha_ok = 1'b0;
				end
				for (int j = i + 1; j < MAX_DIGITS; j++) begin
					if ((LEN_W'(j) < alpha_len) && (alpha_char[j] == alpha_char[i])) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

	// Digit lookup: lowest matching position wins
	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
			if ((LEN_W'(k) < alpha_len) && (alpha_char[k] == byte_s1)) begin
				hit   = 1'b1;
				digit = DIG_W'(k);
			end
		end
	end

	// Handshake: only a terminator needs the output register
	assign is_term     = (byte_s1 == CHAR_NUL);
	assign out_free    = !out_valid_q || out_ready;
	assign advance     = valid_s1 && (!is_term || out_free);
	assign take_result = advance && is_term;
	assign in_ready    = !valid_s1 || advance;
	assign cfg_ready   = 1'b1;

	// Per-character state update
	always_comb begin
		phase_t ph;
		ph      = phase_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		if (is_term) begin
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = '0;
		end else begin
			// leave the whitespace run on its first other character
			if ((ph == PH_SPACE) && !is_space(byte_s1)) begin
				ph = PH_SIGN;
			end
			if (ph == PH_SIGN) begin
				if ((byte_s1 == CHAR_PLUS) || (byte_s1 == CHAR_MINUS)) begin
					neg_d = neg_q ^ (byte_s1 == CHAR_MINUS);
				end else begin
					ph = PH_DIGIT;
				end
			end
			if (ph == PH_DIGIT) begin
				if (hit) begin
					acc_d = VALUE_BITS'(acc_q * VALUE_BITS'(alpha_len)) + VALUE_BITS'(digit);
				end else begin
					ph = PH_BAD;
				end
			end
			phase_d = ph;
		end
	end

	// Result formation, sign-extended or truncated to 32 bits
	assign value      = neg_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
	assign value_wide = 64'(signed'(value));

	always_comb begin
		status_d = STATUS_OK;
		number_d = number_t'(value_wide[31:0]);
		if (!alpha_ok) begin
			status_d = STATUS_BAD_ALPHABET;
			number_d = '0;
		end else if (phase_q == PH_BAD) begin
			status_d = STATUS_BAD_DIGIT;
			number_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
			valid_s1     <= 1'b0;
			byte_s1      <= CHAR_NUL;
			phase_q      <= PH_SPACE;
			neg_q        <= 1'b0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= STATUS_OK;
			number_q     <= '0;
		end else begin
			// configuration beats; unknown indexes are dropped
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ALPHABET_LOW:  alpha_low_q  <= cfg_data;
					REG_ALPHABET_HIGH: alpha_high_q <= cfg_data;
					default: ;
				endcase
			end
			// input register: load on a free slot, hold a stalled terminator
			if (in_ready) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					byte_s1 <= text_byte;
				end
			end
			if (advance) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
			end
			// output register: drop a taken beat, load a fresh result
			if (take_result) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
				number_q    <= number_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign number    = number_q;

	// A fresh result appears only after a terminator left the input register
	a_result_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(take_result))
		else $error("result without terminator");

	// A terminator returns the string state to its reset value
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take_result |=> (phase_q == PH_SPACE) && !neg_q && (acc_q == '0))
		else $error("string state not cleared");

	// A failed conversion carries a zero number
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == STATUS_OK) || (number == '0)))
		else $error("non-zero number with error status");

	// Input stalls only behind a terminator waiting on the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && is_term && out_valid_q && !out_ready))
		else $error("unexpected input stall");

	// A bad digit is sticky until the terminator
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_BAD) && advance && !is_term) |=> (phase_q == PH_BAD))
		else $error("bad digit state lost");

endmodule
